### hdl/rrts_pkg.sv
// Shared types and constants for the round-robin task scheduler.
// Holds the request and response words, operation and status codes.
// No dependencies.
`timescale 1ns / 1ps

package rrts_pkg;

	localparam int ID_W   = 4;
	localparam int TIME_W = 32;

	localparam logic [2:0] OP_ADMIT = 3'd0;
	localparam logic [2:0] OP_TICK  = 3'd1;
	localparam logic [2:0] OP_YIELD = 3'd2;
	localparam logic [2:0] OP_SLEEP = 3'd3;
	localparam logic [2:0] OP_EXIT  = 3'd4;

	localparam logic [1:0] STS_OK   = 2'd0;
	localparam logic [1:0] STS_FULL = 2'd1;
	localparam logic [1:0] STS_HALT = 2'd2;

	typedef struct packed {
		logic [2:0]        operation;
		logic [ID_W-1:0]   task_id;
		logic [TIME_W-1:0] sleep_ticks;
		logic [TIME_W-1:0] current_time;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0] running_task;
		logic            idle;
		logic [1:0]      status;
	} rsp_t;

	// Write command into the wake-up time table.
	typedef struct packed {
		logic              en;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] value;
	} wake_wr_t;

endpackage

### hdl/rrts_ring_mem.sv
// Ready ring storage: one synchronous write port, one read port with
// registered read data. Depends on rrts_pkg.
`timescale 1ns / 1ps

module rrts_ring_mem import rrts_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
	input  logic [ID_W-1:0]                wr_data,
	input  logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
	output logic [ID_W-1:0]                rd_data
);

	logic [ID_W-1:0] ring_mem [QUEUE_DEPTH];
	logic [ID_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= ring_mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### hdl/rrts_wake_mem.sv
// Wake-up time table, one entry per task id, with a registered read and
// the due check against the scheduling time. Depends on rrts_pkg.
`timescale 1ns / 1ps

module rrts_wake_mem import rrts_pkg::*; #(
	parameter int MAX_TASKS = 16
) (
	input  logic              clk,
	input  wake_wr_t          wr,
	input  logic [ID_W-1:0]   rd_id,
	input  logic [TIME_W-1:0] now,
	output logic              due
);

	localparam int AW = $clog2(MAX_TASKS);
	localparam int XW = (AW > ID_W) ? AW : ID_W;

	logic [TIME_W-1:0] wake_mem [MAX_TASKS];
	logic [TIME_W-1:0] rd_data_q;
	logic [XW-1:0]     wr_ext;
	logic [XW-1:0]     rd_ext;

	assign wr_ext = XW'(wr.id);
	assign rd_ext = XW'(rd_id);

	always_ff @(posedge clk) begin
		if (wr.en) begin
			wake_mem[wr_ext[AW-1:0]] <= wr.value;
		end
		rd_data_q <= wake_mem[rd_ext[AW-1:0]];
	end

	// A task is runnable once its wake-up time is not later than now.
	assign due = (rd_data_q <= now);

endmodule

### hdl/round_robin_task_scheduler_with_sleep_core.sv
// Round-robin task scheduler with sleep, top level.
// Depends on rrts_pkg, rrts_ring_mem and rrts_wake_mem.
`timescale 1ns / 1ps

// Usage: each request on the req channel (valid/ready) is one scheduler event:
// admit a task, timer tick, yield, sleep or exit. Every request yields exactly
// one response on the rsp channel carrying the running task, the idle flag
// and a status code (ok, full on admit with a full ring or a bad task id,
// halt on exit while idle). Admit, halt and unknown operations skip the scan
// and answer through the done state and the response register. Tick, yield
// and sleep re-queue a running task if the ring has room, and an exit while
// running drops it; both then scan the ready ring for the first task whose
// wake-up time has passed. The scan reads one ring entry per cycle through a
// three-stage pipeline (ring read, wake-time read, compare) and ends as soon
// as a due task reaches the compare stage. A new request is taken only once
// the previous one has finished and its response has been loaded into the
// output register. A finished response waits there, so a stalled receiver
// holds back at most the next request's completion, not its acceptance.
// After reset the scheduler is idle with an empty ring; both memories start
// undefined and hold only entries that have been written, so no clearing
// pass is needed and a request can be accepted as soon as reset is released.
module round_robin_task_scheduler_with_sleep_core import rrts_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	parameter int MAX_TASKS   = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = CW + 1;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	state_t            state_q;
	logic [PW-1:0]     head_q;
	logic [CW-1:0]     count_q;
	logic [ID_W-1:0]   cur_q;
	logic              idle_q;
	logic [1:0]        status_q;
	logic [TIME_W-1:0] now_q;
	logic [CW-1:0]     scan_left_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [PW-1:0]     wr_ptr_q;
	logic              v_s1;
	logic [PW-1:0]     ptr_s1;
	logic              v_s2;
	logic [PW-1:0]     ptr_s2;
	logic [ID_W-1:0]   id_s2;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic            accept;
	logic [SW-1:0]   tail_sum;
	logic [PW-1:0]   tail;
	logic            full;
	logic            id_ok;
	logic            switch_op;
	logic            admit_ok;
	logic            push_cur;
	logic            start_scan;
	logic [1:0]      acc_status;
	logic            due;
	logic            hit;
	logic            rot;
	logic            scan_end;
	logic            issue;
	logic            rsp_load;
	logic            ring_we;
	logic [PW-1:0]   ring_waddr;
	logic [ID_W-1:0] ring_wdata;
	logic [ID_W-1:0] ring_rd;
	wake_wr_t        wake_wr;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;

	always_comb begin
		tail_sum  = SW'(head_q) + SW'(count_q);
		tail      = (tail_sum >= SW'(QUEUE_DEPTH)) ? PW'(tail_sum - SW'(QUEUE_DEPTH))
							: PW'(tail_sum);
		full      = (count_q == CW'(QUEUE_DEPTH));
		id_ok     = (9'(req.task_id) < 9'(MAX_TASKS));
		switch_op = (req.operation == OP_TICK) || (req.operation == OP_YIELD) ||
			(req.operation == OP_SLEEP);
		admit_ok  = accept && (req.operation == OP_ADMIT) && id_ok && !full;
		// The running task goes back to the tail; it is dropped if the ring is full.
		push_cur  = accept && switch_op && !idle_q && !full;
		start_scan = accept && (switch_op || ((req.operation == OP_EXIT) && !idle_q));

		acc_status = STS_OK;
		if ((req.operation == OP_ADMIT) && !(id_ok && !full)) begin
			acc_status = STS_FULL;
		end else if ((req.operation == OP_EXIT) && idle_q) begin
			acc_status = STS_HALT;
		end

		// Scan pipeline: a due task at the compare stage ends the scan; a
		// sleeper is rotated to the tail.
		hit      = (state_q == S_SCAN) && v_s2 && due;
		rot      = (state_q == S_SCAN) && v_s2 && !due;
		issue    = (state_q == S_SCAN) && !hit && (scan_left_q != '0);
		scan_end = (state_q == S_SCAN) && !hit && (scan_left_q == '0) && !v_s1;
		rsp_load = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);
	end

	always_comb begin
		ring_we    = 1'b0;
		ring_waddr = tail;
		ring_wdata = cur_q;
		if (admit_ok || push_cur) begin
			ring_we    = 1'b1;
			ring_wdata = admit_ok ? req.task_id : cur_q;
		end else if (rot) begin
			ring_we    = 1'b1;
			ring_waddr = wr_ptr_q;
			ring_wdata = id_s2;
		end

		wake_wr.en    = 1'b0;
		wake_wr.id    = req.task_id;
		wake_wr.value = '0;
		if (admit_ok) begin
			wake_wr.en = 1'b1;
		end else if (accept && (req.operation == OP_SLEEP) && !idle_q) begin
			wake_wr.en    = 1'b1;
			wake_wr.id    = cur_q;
			wake_wr.value = req.sleep_ticks + req.current_time;
		end
	end

	rrts_ring_mem #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_ring (
		.clk    (clk),
		.wr_en  (ring_we),
		.wr_addr(ring_waddr),
		.wr_data(ring_wdata),
		.rd_addr(rd_ptr_q),
		.rd_data(ring_rd)
	);

	rrts_wake_mem #(
		.MAX_TASKS(MAX_TASKS)
	) u_wake (
		.clk  (clk),
		.wr   (wake_wr),
		.rd_id(ring_rd),
		.now  (now_q),
		.due  (due)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			cur_q       <= '0;
			idle_q      <= 1'b1;
			scan_left_q <= '0;
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (admit_ok || push_cur) begin
							count_q <= count_q + 1'b1;
						end
						if (start_scan) begin
							state_q     <= S_SCAN;
							scan_left_q <= count_q + CW'(push_cur);
							rd_ptr_q    <= head_q;
							wr_ptr_q    <= push_cur ? ptr_inc(tail) : tail;
							v_s1        <= 1'b0;
							v_s2        <= 1'b0;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						cur_q   <= id_s2;
						idle_q  <= 1'b0;
						head_q  <= ptr_inc(ptr_s2);
						count_q <= count_q - 1'b1;
						v_s1    <= 1'b0;
						v_s2    <= 1'b0;
						state_q <= S_DONE;
					end else begin
						if (rot) begin
							wr_ptr_q <= ptr_inc(wr_ptr_q);
						end
						if (issue) begin
							rd_ptr_q    <= ptr_inc(rd_ptr_q);
							scan_left_q <= scan_left_q - 1'b1;
						end
						v_s1 <= issue;
						v_s2 <= v_s1;
						if (scan_end) begin
							// Every queued task sleeps: the ring keeps its order.
							cur_q   <= '0;
							idle_q  <= 1'b1;
							head_q  <= rd_ptr_q;
							v_s1    <= 1'b0;
							v_s2    <= 1'b0;
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			now_q    <= req.current_time;
			status_q <= acc_status;
		end
		if (issue) begin
			ptr_s1 <= rd_ptr_q;
		end
		ptr_s2 <= ptr_s1;
		id_s2  <= ring_rd;
		if (rsp_load) begin
			rsp_q.running_task <= cur_q;
			rsp_q.idle         <= idle_q;
			rsp_q.status       <= status_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("ring count exceeds queue depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		idle_q |-> (cur_q == '0))
		else $error("idle scheduler holds a nonzero running task");

	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 || v_s2) |-> (state_q == S_SCAN))
		else $error("scan pipeline active outside a scan");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("accepted request did not start processing");

endmodule
